// ----- design/fra_pkg.sv -----
// fra_pkg: shared types, constants and saturating helpers for the fasta read index builder
// no dependencies; used by the interfaces, the result queue and the top level
`default_nettype none

package fra_pkg;

	localparam int OFFSET_BITS  = 48;
	localparam int COUNT_BITS   = 32;
	localparam int RES_DEPTH    = 4;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

	localparam logic [7:0] CH_MARK    = 8'h3E;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_LC_A    = 8'h61;
	localparam logic [7:0] CH_LC_Z    = 8'h7A;
	localparam logic [7:0] CASE_GAP   = 8'd32;
	localparam logic [7:0] CH_UC_LOW  = 8'd64;
	localparam logic [7:0] CH_UC_HIGH = 8'd91;

	typedef logic [OFFSET_BITS-1:0] off_t;
	typedef logic [COUNT_BITS-1:0]  cnt_t;

	localparam off_t OFF_MAX = '1;
	localparam cnt_t CNT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_INDEX  = 2'd0,
		KIND_EMPTY  = 2'd1,
		KIND_TOTALS = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_SEEK   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_SEQ    = 4'b0100,
		PH_HALT   = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t kind;
		off_t  read_start;
		off_t  acc_before;
		off_t  read_length;
		cnt_t  reads_seen;
		off_t  total_letters;
		logic  last_of_run;
	} res_t;

	// up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic is_letter(input logic [7:0] b);
		logic [7:0] u;
		u = (b >= CH_LC_A && b <= CH_LC_Z) ? b - CASE_GAP : b;
		return (u > CH_UC_LOW) && (u < CH_UC_HIGH);
	endfunction

	function automatic off_t off_inc(input off_t a);
		return (a == OFF_MAX) ? a : a + off_t'(1);
	endfunction

	function automatic cnt_t cnt_inc(input cnt_t a);
		return (a == CNT_MAX) ? a : a + cnt_t'(1);
	endfunction

	function automatic off_t off_add(input off_t a, input off_t b);
		logic [OFFSET_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
	endfunction

	// a + b + 1, saturating; same as adding a saturated (b + 1)
	function automatic off_t off_add1(input off_t a, input off_t b);
		logic [OFFSET_BITS:0] s;
		s = {1'b0, a} + {1'b0, b} + (OFFSET_BITS+1)'(1);
		return (s > {1'b0, OFF_MAX}) ? OFF_MAX : s[OFFSET_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/fra_if.sv -----
// fra_if: valid/ready channel interfaces for text bytes in and index words out
// depends on fra_pkg
`default_nettype none

interface fra_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_final;

	modport source(output valid, output data_byte, output is_final, input ready);
	modport sink(input valid, input data_byte, input is_final, output ready);
endinterface

interface fra_index_if import fra_pkg::*;;
	logic  valid;
	logic  ready;
	kind_t kind;
	off_t  read_start;
	off_t  acc_before;
	off_t  read_length;
	cnt_t  reads_seen;
	off_t  total_letters;
	logic  last_of_run;

	modport source(output valid, output kind, output read_start, output acc_before,
		output read_length, output reads_seen, output total_letters, output last_of_run,
		input ready);
	modport sink(input valid, input kind, input read_start, input acc_before,
		input read_length, input reads_seen, input total_letters, input last_of_run,
		output ready);
endinterface

`default_nettype wire

// ----- design/fasta_read_index_builder.sv -----
// fasta_read_index_builder: byte-wide fasta scanner that emits per-read index words and totals
// an accepted byte goes through the input register and then the result queue to index
// throughput: one byte per cycle while the 4-word result queue holds two or fewer words
// a byte may produce up to two words (record then empty-read error, or record then totals)
// reset (arst_n low) clears the scan state, counters and queue; an empty read halts until reset
// depends on fra_pkg, fra_if, fra_res_fifo
`default_nettype none

module fasta_read_index_builder import fra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fra_text_if.sink    text,
	fra_index_if.source index
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// scan state
	phase_t phase_q;
	off_t   off_q;     // offset of the next byte
	off_t   start_q;   // offset of the open read's marker
	off_t   len_q;     // letters in the open read
	off_t   acc_q;     // running acc_before
	off_t   ltot_q;    // letters over all indexed reads
	cnt_t   rtot_q;    // reads indexed

	logic [RES_CNT_BITS-1:0] fifo_cnt;
	logic                    adv;
	logic                    step;
	logic                    accept;
	logic                    pop;
	push_t                   push;
	res_t                    head;
	logic                    head_valid;

	// decode of the byte in the input register
	logic   in_seek, in_header, in_seq, in_halt;
	logic   gt, nl, let_b;
	logic   close_a, close_b, closing, c_empty, grow, tail_en;
	off_t   len_upd, c_len, c_start, acc_p, ltot_p;
	cnt_t   rtot_p;
	res_t   r_close, r_tail;

	// next state
	phase_t phase_n;
	off_t   off_n, start_n, len_n, acc_n, ltot_n;
	cnt_t   rtot_n;

	// the stage advances only when the queue can take two words
	assign adv        = (fifo_cnt <= RES_CNT_BITS'(RES_DEPTH - 2));
	assign step       = valid_s1 && adv;
	assign text.ready = !valid_s1 || adv;
	assign accept     = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= text.data_byte;
			final_s1 <= text.is_final;
		end
	end

	always_comb begin
		in_seek   = (phase_q == PH_SEEK);
		in_header = (phase_q == PH_HEADER);
		in_seq    = (phase_q == PH_SEQ);
		in_halt   = (phase_q == PH_HALT);
		gt        = (byte_s1 == CH_MARK);
		nl        = (byte_s1 == CH_NL);
		let_b     = is_letter(byte_s1);

		len_upd = (in_seq && !gt && let_b) ? off_inc(len_q) : len_q;

		// a marker inside a sequence closes the open read; the final byte closes
		// whatever read is open, including one opened by this very byte
		close_a = in_seq && gt;
		close_b = final_s1 && !close_a && (in_header || in_seq || (in_seek && gt));
		closing = close_a || close_b;
		c_len   = in_seek ? '0 : len_upd;
		c_start = in_seek ? off_q : start_q;
		c_empty = (c_len == '0);
		grow    = closing && !c_empty;

		rtot_p = grow ? cnt_inc(rtot_q) : rtot_q;
		ltot_p = grow ? off_add(ltot_q, c_len) : ltot_q;
		acc_p  = grow ? off_add1(acc_q, c_len) : acc_q;

		// second word: totals, or the error for the read a final marker opens
		tail_en = final_s1 && !(closing && c_empty);

		r_close.kind          = c_empty ? KIND_EMPTY : KIND_INDEX;
		r_close.read_start    = c_start;
		r_close.acc_before    = acc_q;
		r_close.read_length   = c_len;
		r_close.reads_seen    = rtot_p;
		r_close.total_letters = ltot_p;
		r_close.last_of_run   = !tail_en;

		r_tail.kind          = close_a ? KIND_EMPTY : KIND_TOTALS;
		r_tail.read_start    = close_a ? off_q : '0;
		r_tail.acc_before    = close_a ? acc_p : '0;
		r_tail.read_length   = '0;
		r_tail.reads_seen    = rtot_p;
		r_tail.total_letters = ltot_p;
		r_tail.last_of_run   = 1'b1;

		push.n  = '0;
		push.r0 = closing ? r_close : r_tail;
		push.r1 = r_tail;

		phase_n = phase_q;
		off_n   = off_q;
		start_n = start_q;
		len_n   = len_q;
		acc_n   = acc_q;
		ltot_n  = ltot_q;
		rtot_n  = rtot_q;

		if (step && !in_halt) begin
			push.n = {1'b0, closing} + {1'b0, tail_en};
			if ((closing && c_empty) || (tail_en && close_a)) begin
				// empty read: stop for good
				phase_n = PH_HALT;
			end else if (final_s1) begin
				// totals sent, ready for a new file
				phase_n = PH_SEEK;
				off_n   = '0;
				start_n = '0;
				len_n   = '0;
				acc_n   = '0;
				ltot_n  = '0;
				rtot_n  = '0;
			end else begin
				off_n = off_inc(off_q);
				case (phase_q)
					PH_SEEK: begin
						if (gt) begin
							start_n = off_q;
							len_n   = '0;
							phase_n = PH_HEADER;
						end
					end
					PH_HEADER: begin
						if (nl) begin
							phase_n = PH_SEQ;
						end
					end
					PH_SEQ: begin
						if (gt) begin
							start_n = off_q;
							len_n   = '0;
							acc_n   = acc_p;
							ltot_n  = ltot_p;
							rtot_n  = rtot_p;
							phase_n = PH_HEADER;
						end else begin
							len_n = len_upd;
						end
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			off_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			ltot_q  <= '0;
			rtot_q  <= '0;
		end else begin
			phase_q <= phase_n;
			off_q   <= off_n;
			start_q <= start_n;
			len_q   <= len_n;
			acc_q   <= acc_n;
			ltot_q  <= ltot_n;
			rtot_q  <= rtot_n;
		end
	end

	// result queue doubles as the output register
	fra_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (fifo_cnt)
	);

	assign pop                 = head_valid && index.ready;
	assign index.valid         = head_valid;
	assign index.kind          = head.kind;
	assign index.read_start    = head.read_start;
	assign index.acc_before    = head.acc_before;
	assign index.read_length   = head.read_length;
	assign index.reads_seen    = head.reads_seen;
	assign index.total_letters = head.total_letters;
	assign index.last_of_run   = head.last_of_run;

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("left halt without reset");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> (push.r1.last_of_run && !push.r0.last_of_run))
		else $error("last_of_run misplaced in a word pair");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && final_s1) |=> (phase_q == PH_SEEK || phase_q == PH_HALT))
		else $error("final byte left a read open");

	a_totals_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r0.kind != KIND_TOTALS)
		else $error("totals word not last");

endmodule

`default_nettype wire

// ----- design/fra_res_fifo.sv -----
// fra_res_fifo: small result queue, takes up to two words per cycle, gives one
// depends on fra_pkg
`default_nettype none

module fra_res_fifo import fra_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  push_t                   push,
	input  logic                    pop,
	output res_t                    head,
	output logic                    head_valid,
	output logic [RES_CNT_BITS-1:0] count
);

	res_t                    mem_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] wr_ptr_q;
	logic [RES_PTR_BITS-1:0] rd_ptr_q;
	logic [RES_CNT_BITS-1:0] cnt_q;
	logic [RES_PTR_BITS-1:0] wr_ptr1;

	assign wr_ptr1    = wr_ptr_q + RES_PTR_BITS'(1);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_BITS'(push.n);
			rd_ptr_q <= rd_ptr_q + RES_PTR_BITS'(pop);
			cnt_q    <= cnt_q + RES_CNT_BITS'(push.n) - RES_CNT_BITS'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RES_CNT_BITS'(RES_DEPTH))
		else $error("result queue count out of range");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= RES_CNT_BITS'(RES_DEPTH - 2))
		else $error("push without room for two words");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd0 && !pop) |=> cnt_q == $past(cnt_q))
		else $error("queue count moved with no push or pop");

endmodule

`default_nettype wire
